// ----- rtl/rvps_pkg.sv -----
// Package for the refrigerant valve position sequencer: payload, configuration
// and state types, operation and register codes, phase codes and reset values.
// No dependencies.
`default_nettype none

package rvps_pkg;

  // Operation codes carried by an input transaction. Codes 5 to 7 act as none.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_HOME = 3'd1;
  localparam logic [2:0] OP_COLD = 3'd2;
  localparam logic [2:0] OP_ICE  = 3'd3;
  localparam logic [2:0] OP_HOT  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_POWER_ON_TICKS = 3'd0;
  localparam logic [2:0] REG_COLD_POSITION  = 3'd1;
  localparam logic [2:0] REG_ICE_POSITION   = 3'd2;
  localparam logic [2:0] REG_HOTGAS_POSITION = 3'd3;
  localparam logic [2:0] REG_HOME_OVERDRIVE = 3'd4;
  localparam logic [2:0] REG_PARK_POSITION  = 3'd5;

  // Pending-mode bit positions, in service priority order.
  localparam int unsigned MB_HOME = 0;
  localparam int unsigned MB_COLD = 1;
  localparam int unsigned MB_ICE  = 2;
  localparam int unsigned MB_HOT  = 3;

  // Valve status codes.
  localparam logic [1:0] ST_COLD = 2'd0;
  localparam logic [1:0] ST_ICE  = 2'd1;
  localparam logic [1:0] ST_HOT  = 2'd2;

  // Phase codes shared by the home and goto sequences.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_WAIT  = 3'd1;
  // Home sequence.
  localparam logic [2:0] PH_H_OVERDRIVE = 3'd2;
  localparam logic [2:0] PH_H_OD_WAIT   = 3'd3;
  localparam logic [2:0] PH_H_TO_COLD   = 3'd4;
  localparam logic [2:0] PH_H_COLD_WAIT = 3'd5;
  localparam logic [2:0] PH_H_DONE      = 3'd6;
  // Cold, ice and hot gas sequences.
  localparam logic [2:0] PH_G_CHECK     = 3'd2;
  localparam logic [2:0] PH_G_MOVE      = 3'd3;
  localparam logic [2:0] PH_G_MOVE_WAIT = 3'd4;
  localparam logic [2:0] PH_G_DONE      = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [7:0]        RST_POWER_ON_TICKS = 8'd10;
  localparam logic signed [9:0] RST_COLD_POSITION  = 10'sd24;
  localparam logic signed [9:0] RST_ICE_POSITION   = 10'sd64;
  localparam logic signed [9:0] RST_HOTGAS_POSITION = 10'sd104;
  localparam logic signed [9:0] RST_HOME_OVERDRIVE = -10'sd15;
  localparam logic signed [9:0] RST_PARK_POSITION  = 10'sd200;

  typedef struct packed {
    logic [2:0] operation;
    logic       move_done;
  } rvps_in_t;

  typedef struct packed {
    logic signed [9:0] target_step;
    logic              target_write;
    logic              zero_position;
    logic [1:0]        valve_status;
    logic [3:0]        pending_modes;
  } rvps_out_t;

  typedef struct packed {
    logic [7:0]        power_on_ticks;
    logic signed [9:0] cold_position;
    logic signed [9:0] ice_position;
    logic signed [9:0] hotgas_position;
    logic signed [9:0] home_overdrive_position;
    logic signed [9:0] park_position;
  } rvps_cfg_t;

  typedef struct packed {
    logic [3:0]        mode_bits;
    logic [2:0]        home_phase;
    logic [2:0]        cold_phase;
    logic [2:0]        ice_phase;
    logic [2:0]        hot_phase;
    logic [7:0]        wait_cnt;
    logic signed [9:0] target;
    logic [1:0]        status;
  } rvps_state_t;

endpackage

`default_nettype wire

// ----- rtl/rvps_step.sv -----
// Next-state logic of the valve sequencer for one tick: command intake, then one
// phase of the highest-priority pending sequence. Depends on rvps_pkg.
`default_nettype none

module rvps_step
  import rvps_pkg::*;
(
  input  wire rvps_cfg_t   cfg_i,
  input  wire rvps_state_t st_i,
  input  wire rvps_in_t    in_i,
  output rvps_state_t st_o,
  output rvps_out_t   res_o
);

  rvps_state_t       s;
  logic              wr;
  logic              zr;
  logic [2:0]        g_phase;
  logic signed [9:0] g_goal;
  logic [1:0]        g_status;
  logic              g_fin;

  always_comb begin
    s        = st_i;
    wr       = 1'b0;
    zr       = 1'b0;
    g_phase  = PH_START;
    g_goal   = cfg_i.cold_position;
    g_status = ST_COLD;
    g_fin    = 1'b0;

    // Command intake. A cold, ice or hot gas request cancels the other two.
    case (in_i.operation)
      OP_HOME: begin
        s.mode_bits[MB_HOME] = 1'b1;
      end
      OP_COLD: begin
        s.mode_bits[MB_COLD] = 1'b1;
        s.mode_bits[MB_ICE]  = 1'b0;
        s.mode_bits[MB_HOT]  = 1'b0;
        s.ice_phase          = PH_START;
        s.hot_phase          = PH_START;
      end
      OP_ICE: begin
        s.mode_bits[MB_ICE]  = 1'b1;
        s.mode_bits[MB_COLD] = 1'b0;
        s.mode_bits[MB_HOT]  = 1'b0;
        s.cold_phase         = PH_START;
        s.hot_phase          = PH_START;
      end
      OP_HOT: begin
        s.mode_bits[MB_HOT]  = 1'b1;
        s.mode_bits[MB_COLD] = 1'b0;
        s.mode_bits[MB_ICE]  = 1'b0;
        s.cold_phase         = PH_START;
        s.ice_phase          = PH_START;
      end
      default: ;
    endcase

    // Pick the goto sequence that would run; one shared unit serves all three.
    if (s.mode_bits[MB_COLD]) begin
      g_phase  = s.cold_phase;
      g_goal   = cfg_i.cold_position;
      g_status = ST_COLD;
    end else if (s.mode_bits[MB_ICE]) begin
      g_phase  = s.ice_phase;
      g_goal   = cfg_i.ice_position;
      g_status = ST_ICE;
    end else begin
      g_phase  = s.hot_phase;
      g_goal   = cfg_i.hotgas_position;
      g_status = ST_HOT;
    end

    if (s.mode_bits[MB_HOME]) begin
      unique case (s.home_phase)
        PH_START: begin
          s.wait_cnt   = cfg_i.power_on_ticks;
          s.home_phase = PH_WAIT;
        end
        PH_WAIT: begin
          if (s.wait_cnt != 8'd0) begin
            s.wait_cnt = s.wait_cnt - 8'd1;
          end else begin
            s.home_phase = PH_H_OVERDRIVE;
          end
        end
        PH_H_OVERDRIVE: begin
          s.target     = cfg_i.home_overdrive_position;
          wr           = 1'b1;
          s.home_phase = PH_H_OD_WAIT;
        end
        PH_H_OD_WAIT: begin
          if (in_i.move_done) begin
            s.target     = '0;
            zr           = 1'b1;
            s.home_phase = PH_H_TO_COLD;
          end
        end
        PH_H_TO_COLD: begin
          s.target     = cfg_i.cold_position;
          wr           = 1'b1;
          s.home_phase = PH_H_COLD_WAIT;
        end
        PH_H_COLD_WAIT: begin
          if (in_i.move_done) begin
            s.home_phase = PH_H_DONE;
          end
        end
        PH_H_DONE: begin
          s.mode_bits[MB_HOME] = 1'b0;
          s.home_phase         = PH_START;
          s.status             = ST_COLD;
        end
        default: begin
          s.home_phase = PH_START;
        end
      endcase
    end else if (s.mode_bits[MB_COLD] || s.mode_bits[MB_ICE] || s.mode_bits[MB_HOT]) begin
      unique case (g_phase)
        PH_START: begin
          s.wait_cnt = cfg_i.power_on_ticks;
          g_phase    = PH_WAIT;
        end
        PH_WAIT: begin
          if (s.wait_cnt != 8'd0) begin
            s.wait_cnt = s.wait_cnt - 8'd1;
          end else begin
            g_phase = PH_G_CHECK;
          end
        end
        PH_G_CHECK: begin
          g_phase = (s.target == g_goal) ? PH_G_MOVE_WAIT : PH_G_MOVE;
        end
        PH_G_MOVE: begin
          s.target = g_goal;
          wr       = 1'b1;
          g_phase  = PH_G_MOVE_WAIT;
        end
        PH_G_MOVE_WAIT: begin
          if (in_i.move_done) begin
            g_phase = PH_G_DONE;
          end
        end
        PH_G_DONE: begin
          g_fin    = 1'b1;
          g_phase  = PH_START;
          s.status = g_status;
        end
        default: begin
          g_phase = PH_START;
        end
      endcase

      // Write the shared unit's phase back to the sequence it served.
      if (s.mode_bits[MB_COLD]) begin
        s.cold_phase         = g_phase;
        s.mode_bits[MB_COLD] = ~g_fin;
      end else if (s.mode_bits[MB_ICE]) begin
        s.ice_phase         = g_phase;
        s.mode_bits[MB_ICE] = ~g_fin;
      end else begin
        s.hot_phase         = g_phase;
        s.mode_bits[MB_HOT] = ~g_fin;
      end
    end
  end

  assign st_o                = s;
  assign res_o.target_step   = s.target;
  assign res_o.target_write  = wr;
  assign res_o.zero_position = zr;
  assign res_o.valve_status  = s.status;
  assign res_o.pending_modes = s.mode_bits;

endmodule

`default_nettype wire

// ----- rtl/refrigerant_valve_position_sequencer_top.sv -----
// Top level of the refrigerant valve position sequencer: configuration registers,
// sequencer state, result register and handshakes. Depends on rvps_pkg, rvps_step.
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    rvps_in_t  (operation, move_done)
// out_     output     out_valid / out_ready  rvps_out_t (target, flags, status, pending)
// cfg_     input      cfg_we                 cfg_index selects, cfg_wdata carries value
//
// Each input transaction is one 100 ms tick and yields exactly one output
// transaction in the next cycle; a new tick is taken every cycle unless the output stalls.
// The whole step is one combinational pass from the state registers to the result register.
// in_ready is low only while a result waits and out_ready is low, so a stalled
// output holds the input back without losing or repeating anything.
// Reset (rst_n low, synchronous) restores the register defaults, clears all
// pending modes and phases, parks the target and reports the ice status.

module refrigerant_valve_position_sequencer_top
  import rvps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rvps_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rvps_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_wdata
);

  rvps_cfg_t   cfg_r;
  rvps_state_t state_r;
  rvps_state_t state_nxt;
  rvps_out_t   res_nxt;
  rvps_out_t   out_r;
  logic        out_valid_r;
  logic        in_accept;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_on_ticks          <= RST_POWER_ON_TICKS;
      cfg_r.cold_position           <= RST_COLD_POSITION;
      cfg_r.ice_position            <= RST_ICE_POSITION;
      cfg_r.hotgas_position         <= RST_HOTGAS_POSITION;
      cfg_r.home_overdrive_position <= RST_HOME_OVERDRIVE;
      cfg_r.park_position           <= RST_PARK_POSITION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_ON_TICKS:  cfg_r.power_on_ticks          <= cfg_wdata[7:0];
        REG_COLD_POSITION:   cfg_r.cold_position           <= cfg_wdata;
        REG_ICE_POSITION:    cfg_r.ice_position            <= cfg_wdata;
        REG_HOTGAS_POSITION: cfg_r.hotgas_position         <= cfg_wdata;
        REG_HOME_OVERDRIVE:  cfg_r.home_overdrive_position <= cfg_wdata;
        REG_PARK_POSITION:   cfg_r.park_position           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle that its result is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  rvps_step u_step (
    .cfg_i (cfg_r),
    .st_i  (state_r),
    .in_i  (in_data),
    .st_o  (state_nxt),
    .res_o (res_nxt)
  );

  // Sequencer state advances once per accepted tick. The wait counter and the
  // target take their reset values from the register defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode_bits  <= '0;
      state_r.home_phase <= PH_START;
      state_r.cold_phase <= PH_START;
      state_r.ice_phase  <= PH_START;
      state_r.hot_phase  <= PH_START;
      state_r.wait_cnt   <= RST_POWER_ON_TICKS;
      state_r.target     <= RST_PARK_POSITION;
      state_r.status     <= ST_ICE;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/rvps_chk.sv -----
// Port-level checker for the valve sequencer and its bind to the top level.
// Depends on rvps_pkg and refrigerant_valve_position_sequencer_top.
`default_nettype none

module rvps_chk
  import rvps_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire rvps_out_t  out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing is presented in the cycle after a reset cycle.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Zeroing the position also zeroes the reported target, and never issues one.
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_position |->
      out_data.target_step == 10'sd0 && !out_data.target_write)
    else $error("zeroing with nonzero target or a target write");

  // An input transaction always produces a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

  // Status is always one of the three reached positions.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valve_status == ST_COLD ||
      out_data.valve_status == ST_ICE || out_data.valve_status == ST_HOT)
    else $error("bad valve status");

endmodule

bind refrigerant_valve_position_sequencer_top rvps_chk u_rvps_chk (.*);

`default_nettype wire
